// ===== rtl/mcuie_pkg.sv =====
// ----------------------------------------------------------------------------
// mcuie_pkg: shared types and constants for the instruction execute unit
// Opcode groups, STATUS layout and the control bundle that the execute
// datapath hands to the top level.
// ----------------------------------------------------------------------------
package mcuie_pkg;

   localparam int INSTR_W = 14;
   localparam int DATA_W  = 8;
   localparam int OPC_PC_W = 10;

   // fixed register-file locations
   localparam logic [7:0] ST_ADDR  = 8'd3;
   localparam logic [7:0] FSR_ADDR = 8'd4;
   localparam logic [7:0] BANK_OFS = 8'h80;

   // STATUS bit positions
   localparam int FLAG_C   = 0;
   localparam int FLAG_DC  = 1;
   localparam int FLAG_Z   = 2;
   localparam int FLAG_RP0 = 5;

   // major groups, instr[13:12]
   localparam logic [1:0] GRP_BYTE = 2'd0;
   localparam logic [1:0] GRP_BIT  = 2'd1;
   localparam logic [1:0] GRP_JUMP = 2'd2;
   localparam logic [1:0] GRP_LIT  = 2'd3;

   // byte-oriented ops, instr[11:8]
   localparam logic [3:0] OP_MOVWF  = 4'h0;
   localparam logic [3:0] OP_CLR    = 4'h1;
   localparam logic [3:0] OP_SUBWF  = 4'h2;
   localparam logic [3:0] OP_DECF   = 4'h3;
   localparam logic [3:0] OP_IORWF  = 4'h4;
   localparam logic [3:0] OP_ANDWF  = 4'h5;
   localparam logic [3:0] OP_XORWF  = 4'h6;
   localparam logic [3:0] OP_ADDWF  = 4'h7;
   localparam logic [3:0] OP_MOVF   = 4'h8;
   localparam logic [3:0] OP_COMF   = 4'h9;
   localparam logic [3:0] OP_INCF   = 4'hA;
   localparam logic [3:0] OP_DECFSZ = 4'hB;
   localparam logic [3:0] OP_RRF    = 4'hC;
   localparam logic [3:0] OP_RLF    = 4'hD;
   localparam logic [3:0] OP_SWAPF  = 4'hE;

   localparam logic [13:0] INSTR_RETURN = 14'h0008;

   // bit ops, instr[11:10]
   localparam logic [1:0] BOP_BCF   = 2'd0;
   localparam logic [1:0] BOP_BSF   = 2'd1;
   localparam logic [1:0] BOP_BTFSC = 2'd2;

   // literal ops, instr[11:10] and instr[9:8]
   localparam logic [1:0] LOP_MOVLW = 2'd0;
   localparam logic [1:0] LOP_RETLW = 2'd1;
   localparam logic [1:0] LOP_LOGIC = 2'd2;
   localparam logic [1:0] LGC_IOR   = 2'd0;
   localparam logic [1:0] LGC_AND   = 2'd1;
   localparam logic [1:0] LGC_XOR   = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0]   w_next;
      logic [DATA_W-1:0]   status_next;
      logic                wr_en;
      logic [DATA_W-1:0]   wr_data;
      logic                push;
      logic                pop;
      logic [OPC_PC_W-1:0] push_pc;
   } ctl_type;

endpackage

// ===== rtl/mcuie_if.sv =====
// ----------------------------------------------------------------------------
// mcuie request and response channels
// Valid/ready channels carrying the instruction word and the execute result.
// ----------------------------------------------------------------------------
interface mcuie_req_if;
   logic        valid;
   logic        ready;
   logic [13:0] instr_word;
   modport source (output valid, output instr_word, input ready);
   modport sink   (input valid, input instr_word, output ready);
endinterface

interface mcuie_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] next_pc;
   logic [7:0] w_value;
   logic [7:0] status_value;
   logic       file_write_en;
   logic [7:0] file_write_addr;
   logic [7:0] file_write_data;
   modport source (output valid, output next_pc, output w_value, output status_value,
                   output file_write_en, output file_write_addr,
                   output file_write_data, input ready);
   modport sink   (input valid, input next_pc, input w_value, input status_value,
                   input file_write_en, input file_write_addr,
                   input file_write_data, output ready);
endinterface

// ===== rtl/mcuie_exec.sv =====
// ----------------------------------------------------------------------------
// mcuie_exec: execute datapath
// Decodes one instruction and computes W, flags, file write, stack and PC.
// ----------------------------------------------------------------------------
module mcuie_exec
   import mcuie_pkg::*;
#(
   parameter int PROG_WORDS = 1024
) (
   input  logic [INSTR_W-1:0]            instr,
   input  logic [DATA_W-1:0]             fv,
   input  logic [DATA_W-1:0]             w,
   input  logic [DATA_W-1:0]             status,
   input  logic [$clog2(PROG_WORDS)-1:0] pc,
   input  logic [OPC_PC_W-1:0]           stack_top,
   output ctl_type                       ctl,
   output logic [$clog2(PROG_WORDS)-1:0] pc_next
);

   localparam int PC_W = $clog2(PROG_WORDS);
   localparam int TW   = ((PC_W > OPC_PC_W) ? PC_W : OPC_PC_W) + 1;

   logic             d;
   logic [2:0]       bsel;
   logic [7:0]       k;
   logic [7:0]       v;
   logic [7:0]       bmask;
   logic [8:0]       w_neg;
   logic             skip;
   logic             jump;
   logic [OPC_PC_W-1:0] jtarget;
   logic [PC_W:0]    inc1;
   logic [PC_W:0]    inc2;
   logic [PC_W:0]    seq;
   logic [TW-1:0]    tj;

   assign d     = instr[7];
   assign bsel  = instr[9:7];
   assign k     = instr[7:0];
   assign bmask = 8'(1) << bsel;
   assign w_neg = 9'(w);

   always_comb begin
      ctl             = '0;
      ctl.w_next      = w;
      ctl.status_next = status;
      skip            = 1'b0;
      jump            = 1'b0;
      jtarget         = instr[9:0];
      v               = 8'd0;
      case (instr[13:12])
         GRP_BYTE: begin
            case (instr[11:8])
               OP_MOVWF: begin
                  if (d) begin
                     ctl.wr_en   = 1'b1;
                     ctl.wr_data = w;
                  end else if (instr == INSTR_RETURN) begin
                     ctl.pop = 1'b1;
                     jump    = 1'b1;
                     jtarget = stack_top;
                  end
               end
               OP_CLR: begin
                  ctl.status_next[FLAG_Z] = 1'b1;
                  v = 8'd0;
               end
               OP_SUBWF: begin
                  v = fv - w;
                  ctl.status_next[FLAG_C]  = (fv >= w);
                  ctl.status_next[FLAG_DC] = (fv[3:0] >= w[3:0]);
                  ctl.status_next[FLAG_Z]  = (v == 8'd0);
               end
               OP_DECF: begin
                  v = fv - 8'd1;
                  ctl.status_next[FLAG_Z] = (v == 8'd0);
               end
               OP_IORWF: begin
                  v = fv | w;
                  ctl.status_next[FLAG_Z] = (v == 8'd0);
               end
               OP_ANDWF: begin
                  v = fv & w;
                  ctl.status_next[FLAG_Z] = (v == 8'd0);
               end
               OP_XORWF: begin
                  v = fv ^ w;
                  ctl.status_next[FLAG_Z] = (v == 8'd0);
               end
               OP_ADDWF: begin
                  v = fv + w;
                  ctl.status_next[FLAG_C]  = (v < w);
                  ctl.status_next[FLAG_DC] = (v[3:0] < w[3:0]);
                  ctl.status_next[FLAG_Z]  = (v == 8'd0);
               end
               OP_MOVF: begin
                  v = fv;
                  ctl.status_next[FLAG_Z] = (v == 8'd0);
               end
               OP_COMF: begin
                  v = ~fv;
                  ctl.status_next[FLAG_Z] = (v == 8'd0);
               end
               OP_INCF: begin
                  v = fv + 8'd1;
                  ctl.status_next[FLAG_Z] = (v == 8'd0);
               end
               OP_DECFSZ: begin
                  v    = fv - 8'd1;
                  skip = (v == 8'd0);
               end
               OP_RRF: begin
                  v = {status[FLAG_C], fv[7:1]};
                  ctl.status_next[FLAG_C] = fv[0];
               end
               OP_RLF: begin
                  v = {fv[6:0], status[FLAG_C]};
                  ctl.status_next[FLAG_C] = fv[7];
               end
               OP_SWAPF: v = {fv[3:0], fv[7:4]};
               default: begin          // incfsz
                  v    = fv + 8'd1;
                  skip = (v == 8'd0);
               end
            endcase
            if (instr[11:8] != OP_MOVWF) begin
               if (d) begin
                  ctl.wr_en   = 1'b1;
                  ctl.wr_data = v;
               end else begin
                  ctl.w_next = v;
               end
            end
         end
         GRP_BIT: begin
            case (instr[11:10])
               BOP_BCF: begin
                  ctl.wr_en   = 1'b1;
                  ctl.wr_data = fv & ~bmask;
               end
               BOP_BSF: begin
                  ctl.wr_en   = 1'b1;
                  ctl.wr_data = fv | bmask;
               end
               BOP_BTFSC: skip = ((fv & bmask) == 8'd0);
               default:   skip = ((fv & bmask) != 8'd0);
            endcase
         end
         GRP_JUMP: begin
            jump     = 1'b1;
            ctl.push = ~instr[11];
         end
         default: begin
            case (instr[11:10])
               LOP_MOVLW: ctl.w_next = k;
               LOP_RETLW: begin
                  ctl.w_next = k;
                  ctl.pop    = 1'b1;
                  jump       = 1'b1;
                  jtarget    = stack_top;
               end
               LOP_LOGIC: begin
                  case (instr[9:8])
                     LGC_IOR: v = k | w;
                     LGC_AND: v = k & w;
                     LGC_XOR: v = k ^ w;
                     default: v = w;
                  endcase
                  if (instr[9:8] != 2'd3) begin
                     ctl.status_next[FLAG_Z] = (v == 8'd0);
                     ctl.w_next = v;
                  end
               end
               default: begin
                  if (instr[9]) begin
                     v = k + w;
                     ctl.status_next[FLAG_C]  = (v < w);
                     ctl.status_next[FLAG_DC] = (v[3:0] < w[3:0]);
                  end else begin
                     v = k - w;
                     ctl.status_next[FLAG_C]  = (9'(k) >= w_neg);
                     ctl.status_next[FLAG_DC] = (k[3:0] >= w[3:0]);
                  end
                  ctl.status_next[FLAG_Z] = (v == 8'd0);
                  ctl.w_next = v;
               end
            endcase
         end
      endcase
   end

   // sequential PC, modulo program size
   always_comb begin
      inc1 = (PC_W+1)'(pc) + (PC_W+1)'(1);
      if (inc1 >= (PC_W+1)'(PROG_WORDS)) inc1 = inc1 - (PC_W+1)'(PROG_WORDS);
      inc2 = (PC_W+1)'(pc) + (PC_W+1)'(2);
      if (inc2 >= (PC_W+1)'(PROG_WORDS)) inc2 = inc2 - (PC_W+1)'(PROG_WORDS);
      seq  = skip ? inc2 : inc1;
   end

   // jump target, modulo program size (at most three folds)
   always_comb begin
      tj = TW'(jtarget);
      for (int i = 0; i < 3; i++) begin
         if (tj >= TW'(PROG_WORDS)) tj = tj - TW'(PROG_WORDS);
      end
   end

   always_comb begin
      logic [TW-1:0] pp;
      pp          = TW'(inc1);
      ctl.push_pc = pp[OPC_PC_W-1:0];
   end

   assign pc_next = jump ? tj[PC_W-1:0] : seq[PC_W-1:0];

endmodule

// ===== rtl/mcu_instruction_execute_unit.sv =====
// ----------------------------------------------------------------------------
// mcu_instruction_execute_unit: execute stage of an 8-bit accumulator MCU
// One 14-bit instruction word in, one architectural result out.
//
// req channel: instruction word fetched at the last reported next_pc (zero
// after reset). rsp channel: next PC, W, STATUS and the register-file write.
// Both are valid/ready; a request moves when valid and ready are high.
//
// Pipeline: the first stage forms the real file address (banking, FSR
// indirection) and reads the register file into a register, forwarding
// a write retiring the same cycle. The second stage executes and commits
// W, STATUS, PC, stack and file write, loading the response register.
// Throughput is one instruction per cycle while the receiver does not stall.
//
// Reset clears PC, W, STATUS, FSR and every register-file valid bit (an
// unwritten byte reads zero), the return stack, and sets the stack index to
// its last entry. When the receiver stalls, the response register holds, the
// execute register holds behind it and req_ready drops until it drains.
// ----------------------------------------------------------------------------
module mcu_instruction_execute_unit
   import mcuie_pkg::*;
#(
   parameter int STACK_DEPTH = 8,
   parameter int PROG_WORDS  = 1024,
   parameter int FILE_BYTES  = 256
) (
   input  logic        clock,
   input  logic        reset,
   mcuie_req_if.sink   req,
   mcuie_rsp_if.source rsp
);

   localparam int PC_W   = $clog2(PROG_WORDS);
   localparam int ADDR_W = $clog2(FILE_BYTES);
   localparam int SP_W   = $clog2(STACK_DEPTH);

   // architectural state
   logic [PC_W-1:0]     pc_ff;
   logic [DATA_W-1:0]   w_ff;
   logic [DATA_W-1:0]   status_ff;
   logic [DATA_W-1:0]   fsr_ff;             // shadow of file byte 4 for addressing
   logic [SP_W-1:0]     sp_ff;
   logic [OPC_PC_W-1:0] stack_ff [STACK_DEPTH];
   logic [DATA_W-1:0]   mem_ff   [FILE_BYTES];
   logic [FILE_BYTES-1:0] mem_vld_ff;

   // execute stage
   logic              ex_vld_ff;
   logic [INSTR_W-1:0] ex_instr_ff;
   logic [ADDR_W-1:0] ex_addr_ff;
   logic [DATA_W-1:0] ex_mem_ff;
   logic              ex_memv_ff;
   logic              ex_byp_ff;
   logic [DATA_W-1:0] ex_bypd_ff;

   // response register
   logic              rsp_vld_ff;
   logic [9:0]        rsp_pc_ff;
   logic [7:0]        rsp_w_ff;
   logic [7:0]        rsp_st_ff;
   logic              rsp_wen_ff;
   logic [7:0]        rsp_waddr_ff;
   logic [7:0]        rsp_wdata_ff;

   logic              ex_fire;
   logic              req_fire;
   logic [DATA_W-1:0] ex_fv;
   ctl_type           ctl;
   logic [PC_W-1:0]   pc_next;
   logic [DATA_W-1:0] status_commit;
   logic [DATA_W-1:0] status_eff;
   logic [DATA_W-1:0] fsr_eff;
   logic [SP_W-1:0]   sp_up;
   logic [SP_W-1:0]   sp_dn;
   logic [6:0]        req_f;
   logic [8:0]        raw_addr;
   logic [ADDR_W-1:0] addr_in;
   logic              wr_st;
   logic              wr_fsr;

   assign ex_fire  = ex_vld_ff && (!rsp_vld_ff || rsp.ready);
   assign req.ready = !ex_vld_ff || ex_fire;
   assign req_fire = req.valid && req.ready;

   // operand: forwarded write, else stored byte, unwritten bytes read zero
   assign ex_fv = ex_byp_ff ? ex_bypd_ff : (ex_memv_ff ? ex_mem_ff : '0);

   mcuie_exec #(.PROG_WORDS(PROG_WORDS)) u_exec (
      .instr     (ex_instr_ff),
      .fv        (ex_fv),
      .w         (w_ff),
      .status    (status_ff),
      .pc        (pc_ff),
      .stack_top (stack_ff[sp_ff]),
      .ctl       (ctl),
      .pc_next   (pc_next)
   );

   // flags land first, then a file write to STATUS overwrites them
   assign wr_st  = ctl.wr_en && (8'(ex_addr_ff) == ST_ADDR);
   assign wr_fsr = ctl.wr_en && (8'(ex_addr_ff) == FSR_ADDR);
   assign status_commit = wr_st ? ctl.wr_data : ctl.status_next;

   // addressing sees the state left by the instruction retiring this cycle
   assign status_eff = ex_fire ? status_commit : status_ff;
   assign fsr_eff    = (ex_fire && wr_fsr) ? ctl.wr_data : fsr_ff;

   assign req_f = req.instr_word[6:0];
   always_comb begin
      if (req_f == 7'd0) begin
         raw_addr = 9'(fsr_eff);
      end else if (status_eff[FLAG_RP0] && req_f != 7'(ST_ADDR)
                   && req_f != 7'(FSR_ADDR) && req_f != 7'd2) begin
         raw_addr = 9'(BANK_OFS | 8'(req_f));
      end else begin
         raw_addr = 9'(req_f);
      end
      if (raw_addr >= 9'(FILE_BYTES)) raw_addr = raw_addr - 9'(FILE_BYTES);
      addr_in = raw_addr[ADDR_W-1:0];
   end

   assign sp_up = (sp_ff == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_ff + SP_W'(1);
   assign sp_dn = (sp_ff == '0) ? SP_W'(STACK_DEPTH - 1) : sp_ff - SP_W'(1);

   // register file
   always_ff @(posedge clock) begin
      if (ex_fire && ctl.wr_en) begin
         mem_ff[ex_addr_ff] <= ctl.wr_data;
      end
      if (req_fire) begin
         ex_mem_ff <= mem_ff[addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_vld_ff <= '0;
      end else if (ex_fire && ctl.wr_en) begin
         mem_vld_ff[ex_addr_ff] <= 1'b1;
      end
   end

   // execute stage load
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff <= 1'b0;
      end else if (req_fire) begin
         ex_vld_ff <= 1'b1;
      end else if (ex_fire) begin
         ex_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ex_instr_ff <= req.instr_word;
         ex_addr_ff  <= addr_in;
         ex_memv_ff  <= mem_vld_ff[addr_in];
         ex_byp_ff   <= (addr_in == ADDR_W'(ST_ADDR)) ||
                        (ex_fire && ctl.wr_en && ex_addr_ff == addr_in);
         ex_bypd_ff  <= (addr_in == ADDR_W'(ST_ADDR)) ? status_eff : ctl.wr_data;
      end
   end

   // architectural commit
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         w_ff      <= '0;
         status_ff <= '0;
         fsr_ff    <= '0;
         sp_ff     <= SP_W'(STACK_DEPTH - 1);
         for (int i = 0; i < STACK_DEPTH; i++) begin
            stack_ff[i] <= '0;
         end
      end else if (ex_fire) begin
         pc_ff     <= pc_next;
         w_ff      <= ctl.w_next;
         status_ff <= status_commit;
         fsr_ff    <= fsr_eff;
         if (ctl.push) begin
            sp_ff           <= sp_dn;
            stack_ff[sp_dn] <= ctl.push_pc;
         end else if (ctl.pop) begin
            sp_ff <= sp_up;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (ex_fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      logic [15:0] pc_ext;
      pc_ext = 16'(pc_next);
      if (ex_fire) begin
         rsp_pc_ff    <= pc_ext[9:0];
         rsp_w_ff     <= ctl.w_next;
         rsp_st_ff    <= status_commit;
         rsp_wen_ff   <= ctl.wr_en;
         rsp_waddr_ff <= ctl.wr_en ? 8'(ex_addr_ff) : 8'd0;
         rsp_wdata_ff <= ctl.wr_en ? ctl.wr_data : 8'd0;
      end
   end

   assign rsp.valid           = rsp_vld_ff;
   assign rsp.next_pc         = rsp_pc_ff;
   assign rsp.w_value         = rsp_w_ff;
   assign rsp.status_value    = rsp_st_ff;
   assign rsp.file_write_en   = rsp_wen_ff;
   assign rsp.file_write_addr = rsp_waddr_ff;
   assign rsp.file_write_data = rsp_wdata_ff;

   // a request only enters a full execute stage when that stage retires
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_fire && ex_vld_ff |-> ex_fire)
      else $error("execute stage overwritten");

   // a write to STATUS becomes the committed status
   a_status_write: assert property (@(posedge clock) disable iff (reset)
      ex_fire && wr_st |=> status_ff == $past(ctl.wr_data))
      else $error("STATUS write lost");

   // FSR shadow tracks writes to its file byte
   a_fsr_shadow: assert property (@(posedge clock) disable iff (reset)
      ex_fire && wr_fsr |=> fsr_ff == $past(ctl.wr_data))
      else $error("FSR shadow stale");

   // stack index comes out of reset on the last entry
   a_sp_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> sp_ff == SP_W'(STACK_DEPTH - 1))
      else $error("stack index reset");

endmodule

// ===== tb/mcuie_tb_if.sv =====
// ----------------------------------------------------------------------------
// mcuie_tb_if: channel interfaces for the execute unit testbench
// The bench instantiates the block's own mcuie_req_if and mcuie_rsp_if
// channels directly; nothing further is declared here.
// ----------------------------------------------------------------------------

// ===== tb/mcu_instruction_execute_unit_tb.sv =====
// ----------------------------------------------------------------------------
// mcu_instruction_execute_unit_tb: regression for the instruction execute unit
// Feeds instruction words at random pace, predicts every architectural result
// with an in-bench model of the core and compares each response field.
// ----------------------------------------------------------------------------
module mcu_instruction_execute_unit_tb;
   import mcuie_pkg::*;

   localparam int STACK_N     = 8;
   localparam int WATCHDOG    = 2000;
   localparam int RAND_ITEMS  = 930;

   typedef struct packed {
      logic [9:0] next_pc;
      logic [7:0] w_value;
      logic [7:0] status_value;
      logic       file_write_en;
      logic [7:0] file_write_addr;
      logic [7:0] file_write_data;
   } exec_result_type;

   // Core model plus queue of predicted results.
   class exec_scoreboard;
      logic [9:0]   pc;
      logic [7:0]   wreg;
      logic [7:0]   regs [256];
      logic [9:0]   ret_stack [STACK_N];
      int           sp;
      exec_result_type pending [$];
      int           errors;

      function void clear();
         pc = '0; wreg = '0; sp = STACK_N - 1; errors = 0;
         foreach (regs[i]) regs[i] = '0;
         foreach (ret_stack[i]) ret_stack[i] = '0;
      endfunction

      function logic [7:0] file_addr(logic [6:0] f);
         if (f == 0) return regs[FSR_ADDR];
         if (regs[ST_ADDR][FLAG_RP0] && f != 2 && f != 7'(ST_ADDR) && f != 7'(FSR_ADDR))
            return {1'b0, f} + BANK_OFS;
         return {1'b0, f};
      endfunction

      function void set_flag(int bitpos, logic on);
         regs[ST_ADDR][bitpos] = on;
      endfunction

      // Execute one instruction and queue the result.
      function void note_instr(logic [13:0] iw);
         exec_result_type r;
         logic [7:0]   a, fv, w, k, v;
         logic         d, wr, has_v, skip_z;
         logic [2:0]   b;
         logic [10:0]  nxt;
         a = file_addr(iw[6:0]);
         fv = regs[a]; w = wreg; k = iw[7:0]; d = iw[7]; b = iw[9:7];
         nxt = 11'(pc) + 11'd1; wr = 0; has_v = 0; skip_z = 0; v = '0;
         r = '0;
         case (iw[13:12])
            GRP_BYTE: begin
               has_v = 1;
               case (iw[11:8])
                  OP_MOVWF: begin
                     has_v = 0;
                     if (d) begin
                        regs[a] = w; wr = 1; v = w;
                     end else if (iw == INSTR_RETURN) begin
                        nxt = 11'(ret_stack[sp]); sp = (sp + 1) % STACK_N;
                     end
                  end
                  OP_CLR: begin v = 0; set_flag(FLAG_Z, 1); end
                  OP_SUBWF: begin
                     v = fv - w; set_flag(FLAG_C, fv >= w);
                     set_flag(FLAG_DC, fv[3:0] >= w[3:0]); set_flag(FLAG_Z, v == 0);
                  end
                  OP_DECF: begin v = fv - 8'd1; set_flag(FLAG_Z, v == 0); end
                  OP_IORWF: begin v = fv | w; set_flag(FLAG_Z, v == 0); end
                  OP_ANDWF: begin v = fv & w; set_flag(FLAG_Z, v == 0); end
                  OP_XORWF: begin v = fv ^ w; set_flag(FLAG_Z, v == 0); end
                  OP_ADDWF: begin
                     v = fv + w; set_flag(FLAG_C, v < w);
                     set_flag(FLAG_DC, v[3:0] < w[3:0]); set_flag(FLAG_Z, v == 0);
                  end
                  OP_MOVF: begin v = fv; set_flag(FLAG_Z, v == 0); end
                  OP_COMF: begin v = ~fv; set_flag(FLAG_Z, v == 0); end
                  OP_INCF: begin v = fv + 8'd1; set_flag(FLAG_Z, v == 0); end
                  OP_DECFSZ: begin v = fv - 8'd1; skip_z = 1; end
                  OP_RRF: begin
                     v = {regs[ST_ADDR][FLAG_C], fv[7:1]}; set_flag(FLAG_C, fv[0]);
                  end
                  OP_RLF: begin
                     v = {fv[6:0], regs[ST_ADDR][FLAG_C]}; set_flag(FLAG_C, fv[7]);
                  end
                  OP_SWAPF: v = {fv[3:0], fv[7:4]};
                  default: begin v = fv + 8'd1; skip_z = 1; end // incfsz
               endcase
               if (skip_z && v == 0) nxt = nxt + 11'd1;
               if (has_v) begin
                  if (d) begin
                     regs[a] = v; wr = 1;
                  end else wreg = v;
               end
            end
            GRP_BIT: begin
               case (iw[11:10])
                  BOP_BCF: begin v = fv; v[b] = 0; regs[a] = v; wr = 1; end
                  BOP_BSF: begin v = fv; v[b] = 1; regs[a] = v; wr = 1; end
                  BOP_BTFSC: if (!fv[b]) nxt = nxt + 11'd1;
                  default: if (fv[b]) nxt = nxt + 11'd1;
               endcase
            end
            GRP_JUMP: begin
               if (!iw[11]) begin
                  sp = (sp + STACK_N - 1) % STACK_N;
                  ret_stack[sp] = pc + 10'd1;
               end
               nxt = 11'(iw[9:0]);
            end
            default: begin
               case (iw[11:10])
                  LOP_MOVLW: wreg = k;
                  LOP_RETLW: begin
                     wreg = k; nxt = 11'(ret_stack[sp]); sp = (sp + 1) % STACK_N;
                  end
                  LOP_LOGIC: begin
                     if (iw[9:8] != 2'd3) begin
                        case (iw[9:8])
                           LGC_IOR: v = k | w;
                           LGC_AND: v = k & w;
                           default: v = k ^ w;
                        endcase
                        set_flag(FLAG_Z, v == 0); wreg = v;
                     end
                  end
                  default: begin
                     if (iw[9]) begin
                        v = k + w; set_flag(FLAG_C, v < w);
                        set_flag(FLAG_DC, v[3:0] < w[3:0]);
                     end else begin
                        v = k - w; set_flag(FLAG_C, k >= w);
                        set_flag(FLAG_DC, k[3:0] >= w[3:0]);
                     end
                     set_flag(FLAG_Z, v == 0); wreg = v;
                  end
               endcase
            end
         endcase
         pc = nxt[9:0];
         r.next_pc = pc; r.w_value = wreg; r.status_value = regs[ST_ADDR];
         r.file_write_en = wr;
         r.file_write_addr = wr ? a : 8'd0;
         r.file_write_data = wr ? v : 8'd0;
         pending.push_back(r);
      endfunction

      task report(string what, logic [9:0] got, logic [9:0] want);
         errors++;
         $display("mismatch %s: got %0h expected %0h", what, got, want);
      endtask

      task check_result(exec_result_type got);
         exec_result_type want;
         if (pending.size() == 0) begin
            report("unexpected response", '0, '0);
            return;
         end
         want = pending.pop_front();
         if (got.next_pc != want.next_pc) report("next_pc", got.next_pc, want.next_pc);
         if (got.w_value != want.w_value) report("w_value", got.w_value, want.w_value);
         if (got.status_value != want.status_value)
            report("status_value", got.status_value, want.status_value);
         if (got.file_write_en != want.file_write_en)
            report("file_write_en", got.file_write_en, want.file_write_en);
         if (got.file_write_addr != want.file_write_addr)
            report("file_write_addr", got.file_write_addr, want.file_write_addr);
         if (got.file_write_data != want.file_write_data)
            report("file_write_data", got.file_write_data, want.file_write_data);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   mcuie_req_if req ();
   mcuie_rsp_if rsp ();

   mcu_instruction_execute_unit DUT (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   exec_scoreboard sb;
   bit  hold_rsp = 0;     // long receiver stall, driven by its own process
   int  idle_cycles = 0;
   logic [13:0] instr_q [$];

   // Accepted traffic is sampled at the edge: requests feed the model, responses are checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) sb.note_instr(req.instr_word);
         if (rsp.valid && rsp.ready)
            sb.check_result({rsp.next_pc, rsp.w_value, rsp.status_value,
                             rsp.file_write_en, rsp.file_write_addr, rsp.file_write_data});
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("mcu_instruction_execute_unit regression: fail");
            $finish;
         end
      end
   end

   // Random operand with emphasis on special file addresses.
   function logic [6:0] pick_file();
      case ($urandom_range(0, 5))
         0: return 7'd0;                          // indirect through FSR
         1: return 7'(ST_ADDR);
         2: return 7'(FSR_ADDR);
         3: return 7'($urandom_range(2, 4));
         default: return 7'($urandom);
      endcase
   endfunction

   function logic [13:0] random_instr();
      logic [13:0] iw;
      iw = 14'($urandom);
      case ($urandom_range(0, 9))
         0, 1, 2: iw = {GRP_BYTE, iw[11:7], pick_file()};
         3, 4: iw = {GRP_BIT, iw[11:7], pick_file()};
         // toggle bank bit
         5: iw = {GRP_BIT, BOP_BSF, 3'(FLAG_RP0), 7'(ST_ADDR)};
         6: iw = {GRP_BIT, BOP_BCF, 3'(FLAG_RP0), 7'(ST_ADDR)};
         7: if ($urandom_range(0, 1)) iw = INSTR_RETURN;
         default: ;
      endcase
      return iw;
   endfunction

   // valid drops only across a gap, so back-to-back requests stay high
   task send_instr(logic [13:0] iw);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.instr_word <= iw;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // Receiver: random stalls per response, plus the long hold-off.
   initial begin
      int wait_n;
      rsp.ready = 0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp.ready <= 0;
            @(posedge clock);
         end else begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (wait_n != 0) begin
               rsp.ready <= 0;
               repeat (wait_n) @(posedge clock);
            end
            rsp.ready <= 1;
            @(posedge clock);
            while (!(rsp.valid && rsp.ready) && !hold_rsp) @(posedge clock);
         end
      end
   end

   initial begin
      int n;
      sb = new();
      sb.clear();
      req.valid = 0;
      req.instr_word = '0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: field extremes, each group, special cases
      instr_q = '{14'h0000, 14'h3FFF, 14'h30FF, 14'h0084, 14'h3004, 14'h0084, 14'h0880,
                  14'h1683, 14'h00A5, 14'h0825, 14'h1283, 14'h0120, 14'h0225, 14'h0725,
                  14'h0D25, 14'h0C25, 14'h0B25, 14'h0F25, 14'h1825, 14'h1C25, 14'h2123,
                  14'h2345, 14'h0008, 14'h3455, 14'h3E10};
      foreach (instr_q[i]) send_instr(instr_q[i]);

      fork
         begin
            repeat (200) @(posedge clock);
            hold_rsp = 1;
            repeat (150) @(posedge clock);
            hold_rsp = 0;
         end
      join_none

      for (n = 0; n < RAND_ITEMS; n++) send_instr(random_instr());
      req.valid <= 0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("mcu_instruction_execute_unit regression: pass");
      else $display("mcu_instruction_execute_unit regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mcuie_pkg.sv
rtl/mcuie_if.sv
rtl/mcuie_exec.sv
rtl/mcu_instruction_execute_unit.sv
tb/mcuie_tb_if.sv
tb/mcu_instruction_execute_unit_tb.sv
